// ===== sv/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg - shared types for the indexed sequential list
// Operation and status codes, controller states, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 3'd0,
    FUNC_DELETE  = 3'd1,
    FUNC_READ    = 3'd2,
    FUNC_FIND    = 3'd3,
    FUNC_DEL_VAL = 3'd4,
    FUNC_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_SHIFT_DN,
    S_SCAN,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_POS_M1
  } rd_src_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LD_CNT,
    PTR_LD_POS,
    PTR_LD_ZERO,
    PTR_LD_HIT,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_SHIFT_DN,
    WR_INSERT
  } wr_mode_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_src_t  rd_src;
    ptr_op_t  ptr_op;
    wr_mode_t wr_mode;
    cnt_op_t  cnt_op;
    logic     set_status;
    status_t  code;
    logic     set_found;
    logic     capture_read;
  } isl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_ok;
    logic              ins_pos_ok;
    logic              full;
    logic              more_up;
    logic              more_dn;
    logic              hit;
  } isl_stat_t;

endpackage

// ===== sv/isl_dpath.sv =====
// ----------------------------------------------------------------------------
// isl_dpath - list storage and datapath
// Entry memory with one write and one registered read port, walk pointer,
// entry count, request and result registers.
// ----------------------------------------------------------------------------
module isl_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  isl_pkg::isl_cmd_t             cmd,
  input  logic [isl_pkg::FUNC_W-1:0]    func,
  input  logic [isl_pkg::POS_W-1:0]     position,
  input  logic signed [isl_pkg::VAL_W-1:0] value,
  output isl_pkg::isl_stat_t            stat,
  output logic [isl_pkg::STAT_W-1:0]    status,
  output logic [isl_pkg::POS_W-1:0]     found_position,
  output logic signed [isl_pkg::VAL_W-1:0] read_value,
  output logic [isl_pkg::POS_W-1:0]     count,
  output logic                          is_empty,
  output logic                          is_full
);
  import isl_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VAL_W-1:0]  entries [CAPACITY];

  logic [FUNC_W-1:0] req_func;
  logic [POS_W-1:0]  req_pos;
  logic [VAL_W-1:0]  req_val;

  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [VAL_W-1:0]  rd_q;
  logic [AW-1:0]     rd_idx_q;
  logic              rd_vld_q;

  status_t           status_q;
  logic [POS_W-1:0]  found_q;
  logic [VAL_W-1:0]  rdval_q;

  logic [CW-1:0]     ptr_m1;
  logic [POS_W-1:0]  pos_m1;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign ptr_m1 = ptr - CW'(1);
  assign pos_m1 = req_pos - POS_W'(1);

  always_comb begin
    case (cmd.rd_src)
      RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
      RD_POS_M1: rd_addr = pos_m1[AW-1:0];
      default:   rd_addr = ptr[AW-1:0];
    endcase
  end

  // Shift writes land in the cycle after their read, at the neighbouring slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = rd_q;
    case (cmd.wr_mode)
      WR_SHIFT_UP: begin
        wr_en   = rd_vld_q;
        wr_addr = rd_idx_q + AW'(1);
      end
      WR_SHIFT_DN: begin
        wr_en   = rd_vld_q;
        wr_addr = rd_idx_q - AW'(1);
      end
      WR_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1[AW-1:0];
        wr_data = req_val;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q     <= entries[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_LD_CNT:  ptr_next = cnt;
      PTR_LD_POS:  ptr_next = CW'(req_pos);
      PTR_LD_ZERO: ptr_next = '0;
      PTR_LD_HIT:  ptr_next = CW'(rd_idx_q) + CW'(1);
      PTR_INC:     ptr_next = ptr + CW'(1);
      PTR_DEC:     ptr_next = ptr_m1;
      default:     ptr_next = ptr;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:   cnt_next = cnt + CW'(1);
      CNT_DEC:   cnt_next = cnt - CW'(1);
      CNT_CLEAR: cnt_next = '0;
      default:   cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt      <= cnt_next;
      rd_vld_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load) begin
      req_func <= func;
      req_pos  <= position;
      req_val  <= value;
      status_q <= ST_OK;
      found_q  <= '0;
      rdval_q  <= '0;
    end
    if (cmd.set_status) begin
      status_q <= cmd.code;
    end
    if (cmd.set_found) begin
      found_q <= POS_W'(rd_idx_q) + POS_W'(1);
    end
    if (cmd.capture_read) begin
      rdval_q <= rd_q;
    end
  end

  always_comb begin
    stat.func       = req_func;
    stat.pos_ok     = (req_pos != '0) && (CMP_W'(req_pos) <= CMP_W'(cnt));
    stat.ins_pos_ok = (req_pos != '0) && (CMP_W'(req_pos) <= CMP_W'(cnt) + CMP_W'(1));
    stat.full       = (cnt == CAP_C);
    stat.more_up    = (CMP_W'(ptr) >= CMP_W'(req_pos));
    stat.more_dn    = (ptr < cnt);
    stat.hit        = rd_vld_q && (rd_q == req_val);
  end

  assign status         = status_q;
  assign found_position = found_q;
  assign read_value     = rdval_q;
  assign count          = POS_W'(cnt);
  assign is_empty       = (cnt == '0);
  assign is_full        = (cnt == CAP_C);

endmodule

// ===== sv/isl_ctrl.sv =====
// ----------------------------------------------------------------------------
// isl_ctrl - operation sequencer
// Checks the request, walks the entries for shifts and scans, and raises the
// result strobe for one cycle.
// ----------------------------------------------------------------------------
module isl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  isl_pkg::isl_stat_t stat,
  output isl_pkg::isl_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import isl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_DONE;
        unique case (stat.func) inside
          FUNC_INSERT: begin
            if (!stat.ins_pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.code       = ST_BADPOS;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.code       = ST_FULL;
            end else begin
              cmd.ptr_op = PTR_LD_CNT;
              state_next = S_SHIFT_UP;
            end
          end
          FUNC_DELETE: begin
            if (!stat.pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.code       = ST_BADPOS;
            end else begin
              cmd.ptr_op = PTR_LD_POS;
              state_next = S_SHIFT_DN;
            end
          end
          FUNC_READ: begin
            if (!stat.pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.code       = ST_BADPOS;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_POS_M1;
              state_next = S_READ_WAIT;
            end
          end
          FUNC_FIND, FUNC_DEL_VAL: begin
            cmd.ptr_op = PTR_LD_ZERO;
            state_next = S_SCAN;
          end
          FUNC_CLEAR: begin
            cmd.cnt_op = CNT_CLEAR;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SHIFT_UP: begin
        // Read one below the pointer; the datapath drops last cycle's word one slot up
        cmd.wr_mode = WR_SHIFT_UP;
        if (stat.more_up) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PTR_M1;
          cmd.ptr_op = PTR_DEC;
        end else begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        cmd.wr_mode = WR_INSERT;
        cmd.cnt_op  = CNT_INC;
        state_next  = S_DONE;
      end
      S_SHIFT_DN: begin
        cmd.wr_mode = WR_SHIFT_DN;
        if (stat.more_dn) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PTR;
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          if (stat.func == FUNC_FIND) begin
            cmd.set_found = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.ptr_op = PTR_LD_HIT;
            state_next = S_SHIFT_DN;
          end
        end else if (stat.more_dn) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PTR;
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_NOTFOUND;
          state_next     = S_DONE;
        end
      end
      S_READ_WAIT: begin
        cmd.capture_read = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/indexed_sequential_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_sequential_list_top - fixed-capacity ordered list of 32-bit values
// Insert, delete, read, find, delete by value and clear on 1-based positions,
// run by a sequencer over a single-port-pair entry memory.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  request   | start, busy         | func, position, value
//  result    | done (one cycle)    | status, found_position, read_value, count,
//            |                     | is_empty, is_full
//
// A request is taken on a clock edge with start high and busy low; busy then
// stays high until the cycle after the done strobe. Shifts and scans walk the
// memory one entry per cycle, so insert, delete, find and delete by value take
// longer the more entries they pass over.
// Reset (rst, synchronous) empties the list; entry storage is not cleared.
// The receiver cannot stall: each result sits on the ports for the done cycle.
//
module indexed_sequential_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [isl_pkg::FUNC_W-1:0]            func,
  input  logic [isl_pkg::POS_W-1:0]             position,
  input  logic signed [isl_pkg::VAL_W-1:0]      value,
  output logic                                  done,
  output logic [isl_pkg::STAT_W-1:0]            status,
  output logic [isl_pkg::POS_W-1:0]             found_position,
  output logic signed [isl_pkg::VAL_W-1:0]      read_value,
  output logic [isl_pkg::POS_W-1:0]             count,
  output logic                                  is_empty,
  output logic                                  is_full
);
  import isl_pkg::*;

  // Command and status between sequencer and datapath
  isl_cmd_t  cmd;
  isl_stat_t stat;

  // Sequencer: check, walk the entries, then strobe the result
  isl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: hold the request, the entries, the count and the result
  isl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .func           (func),
    .position       (position),
    .value          (value),
    .stat           (stat),
    .status         (status),
    .found_position (found_position),
    .read_value     (read_value),
    .count          (count),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

endmodule

// ===== sv/isl_checker.sv =====
// ----------------------------------------------------------------------------
// isl_checker - port-level checks for the indexed sequential list
// Request and result sequencing and the consistency of the reported flags.
// ----------------------------------------------------------------------------
module isl_checker #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [isl_pkg::STAT_W-1:0]   status,
  input logic [isl_pkg::POS_W-1:0]    found_position,
  input logic [isl_pkg::POS_W-1:0]    count,
  input logic                         is_empty,
  input logic                         is_full
);
  import isl_pkg::*;

  localparam logic [POS_W-1:0] CAP_C = POS_W'(CAPACITY);

  // A taken request holds the block busy on the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after a request was taken");

  // Free again right after the result strobe
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after the result strobe");

  // Empty and full flags agree with the count
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> ((is_empty == (count == '0)) && (is_full == (count == CAP_C))))
    else $error("empty or full flag disagrees with count");

  // A full refusal only when the list is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> is_full)
    else $error("full status on a list that is not full");

  // A found position lies inside the list and comes with an ok status
  a_found: assert property (@(posedge clk) disable iff (rst)
    (done && (found_position != '0)) |-> ((status == ST_OK) && (found_position <= count)))
    else $error("found position outside the list");

endmodule

bind indexed_sequential_list_top isl_checker #(
  .CAPACITY (CAPACITY)
) u_isl_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .found_position (found_position),
  .count          (count),
  .is_empty       (is_empty),
  .is_full        (is_full)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for indexed_sequential_list_top
// Drives list requests over the start/busy handshake, keeps a shadow copy of
// the list to predict every result, and checks each done strobe against the
// oldest prediction. A short directed part is followed by phases of random
// requests: fill to capacity, grow, shrink and churn.
// ----------------------------------------------------------------------------
module testbench;
  import isl_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // Codes the block leaves unused: they must do nothing and report ok.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  // Flavours of random phase; each biases the operation mix differently.
  localparam int MODE_FILL   = 0;
  localparam int MODE_GROW   = 1;
  localparam int MODE_SHRINK = 2;
  localparam int MODE_CHURN  = 3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [VAL_W-1:0]  read_value;
    logic [POS_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  // Shadow of the list contents plus the queue of results still to arrive.
  class list_tracker;
    logic [VAL_W-1:0] entries [CAPACITY];
    int               fill;
    list_result_t     awaited [$];
    int               faults;

    function new();
      fill   = 0;
      faults = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function int locate(logic [VAL_W-1:0] v);
      for (int i = 0; i < fill; i++) begin
        if (entries[i] == v) return i + 1;
      end
      return 0;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i < fill; i++) entries[i-1] = entries[i];
      fill--;
    endfunction

    // Apply one accepted request to the shadow and queue the result it owes.
    function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                               logic [VAL_W-1:0] v);
      list_result_t r;
      int           pi;
      int           hit;
      r  = '0;
      pi = p;
      case (f)
        FUNC_INSERT: begin
          // Position check comes first, so a bad position on a full list is bad.
          if (pi < 1 || pi > fill + 1) begin
            r.status = ST_BADPOS;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int i = fill; i >= pi; i--) entries[i] = entries[i-1];
            entries[pi-1] = v;
            fill++;
          end
        end
        FUNC_DELETE: begin
          if (pi < 1 || pi > fill) r.status = ST_BADPOS;
          else remove_at(pi);
        end
        FUNC_READ: begin
          if (pi < 1 || pi > fill) r.status = ST_BADPOS;
          else r.read_value = entries[pi-1];
        end
        FUNC_FIND: begin
          hit = locate(v);
          if (hit == 0) r.status = ST_NOTFOUND;
          else r.found_position = POS_W'(hit);
        end
        FUNC_DEL_VAL: begin
          hit = locate(v);
          if (hit == 0) r.status = ST_NOTFOUND;
          else remove_at(hit);
        end
        FUNC_CLEAR: begin
          fill = 0;
        end
        default: begin
        end
      endcase
      r.count    = POS_W'(fill);
      r.is_empty = (fill == 0);
      r.is_full  = (fill == CAPACITY);
      awaited.push_back(r);
    endfunction

    function void check_result(list_result_t seen);
      list_result_t want;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding", $time);
        return;
      end
      want = awaited.pop_front();
      if (want !== seen) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display({"%0t: mismatch (expected/actual) status %0d/%0d found %0d/%0d ",
                    "read %h/%h count %0d/%0d empty %b/%b full %b/%b"}, $time,
                   want.status, seen.status, want.found_position, seen.found_position,
                   want.read_value, seen.read_value, want.count, seen.count,
                   want.is_empty, seen.is_empty, want.is_full, seen.is_full);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [FUNC_W-1:0]        func = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [VAL_W-1:0]  value = '0;
  logic                     busy;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         found_position;
  logic signed [VAL_W-1:0]  read_value;
  logic [POS_W-1:0]         count;
  logic                     is_empty;
  logic                     is_full;

  list_tracker tracker;
  bit          no_idle = 1'b0;
  int          cycle_count = 0;

  indexed_sequential_list_top #(.CAPACITY(CAPACITY)) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .position       (position),
    .value          (value),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .read_value     (read_value),
    .count          (count),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results cannot be held off: take each one on the edge that closes its
  // done cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result('{status, found_position, read_value, count,
                             is_empty, is_full});
    end
  end

  // Hard stop should the block hang or never raise done.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Present one request and hold it until the block takes it. Call at a
  // rising edge; return at the edge of acceptance, start still high.
  task automatic send(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                      input logic [VAL_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      // Drop start and scramble the fields: the block must ignore them.
      start    <= 1'b0;
      func     <= FUNC_W'($urandom);
      position <= POS_W'($urandom);
      value    <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    func     <= f;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(f, p, v);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  function automatic logic [POS_W-1:0] bad_position(int limit);
    if ($urandom_range(0, 3) == 0) return '0;
    return POS_W'($urandom_range(limit + 1, 255));
  endfunction

  // Extremes, a narrow range that breeds duplicates, or anything at all.
  function automatic logic [VAL_W-1:0] any_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_request(input int mode, output logic [FUNC_W-1:0] f,
                              output logic [POS_W-1:0] p, output logic [VAL_W-1:0] v);
    int               weight [7];
    logic [FUNC_W-1:0] op_of_slot [7];
    int               draw;
    int               slot;
    int               fill;
    op_of_slot = '{FUNC_INSERT, FUNC_DELETE, FUNC_READ, FUNC_FIND, FUNC_DEL_VAL,
                   FUNC_CLEAR, FUNC_SPARE_6};
    // Weights in slot order: insert, delete, read, find, delete value, clear, spare.
    case (mode)
      MODE_FILL:   weight = '{80, 0, 8, 8, 2, 0, 2};
      MODE_GROW:   weight = '{50, 10, 14, 14, 8, 2, 2};
      MODE_SHRINK: weight = '{12, 35, 12, 12, 25, 2, 2};
      default:     weight = '{28, 20, 16, 16, 14, 3, 3};
    endcase
    draw = $urandom_range(0, 99);
    slot = 0;
    while (slot < 6 && draw >= weight[slot]) begin
      draw -= weight[slot];
      slot++;
    end
    f    = op_of_slot[slot];
    fill = tracker.fill;
    if (f == FUNC_SPARE_6 && $urandom_range(0, 1) == 1) f = FUNC_SPARE_7;
    p = POS_W'($urandom);
    v = $urandom;
    case (f)
      FUNC_INSERT: begin
        if ($urandom_range(0, 9) != 0) p = POS_W'($urandom_range(1, fill + 1));
        else p = bad_position(fill + 1);
        v = any_value();
      end
      FUNC_DELETE, FUNC_READ: begin
        if (fill > 0 && $urandom_range(0, 9) != 0) p = POS_W'($urandom_range(1, fill));
        else p = bad_position(fill);
      end
      FUNC_FIND, FUNC_DEL_VAL: begin
        if (fill > 0 && $urandom_range(0, 9) < 7)
          v = tracker.entries[$urandom_range(0, fill - 1)];
        else
          v = any_value();
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    logic [VAL_W-1:0]  v;
    int                issued;
    int                phase_len;
    int                mode;
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation but clear on an empty list first.
    send(FUNC_READ, 8'd1, 32'd0);
    send(FUNC_DELETE, 8'd1, 32'd0);
    send(FUNC_FIND, 8'd0, 32'd0);
    send(FUNC_DEL_VAL, 8'd0, 32'd0);
    // Insert at position zero and beyond the rear are both bad positions.
    send(FUNC_INSERT, 8'd0, 32'd1);
    send(FUNC_INSERT, 8'd2, 32'd1);
    // Build [-1, min, max, max, 0] through rear, head and middle inserts.
    send(FUNC_INSERT, 8'd1, 32'h8000_0000);
    send(FUNC_INSERT, 8'd2, 32'h7fff_ffff);
    send(FUNC_INSERT, 8'd1, 32'hffff_ffff);
    send(FUNC_INSERT, 8'd4, 32'h0000_0000);
    send(FUNC_INSERT, 8'd3, 32'h7fff_ffff);
    // Reads at both ends and at bad positions.
    send(FUNC_READ, 8'd1, 32'd0);
    send(FUNC_READ, 8'd5, 32'd0);
    send(FUNC_READ, 8'd0, 32'd0);
    send(FUNC_READ, 8'd255, 32'd0);
    send(FUNC_READ, 8'd6, 32'd0);
    // Find returns the first of the duplicates; a missing value is not found.
    send(FUNC_FIND, 8'd0, 32'h7fff_ffff);
    send(FUNC_FIND, 8'd0, 32'd12345);
    send(FUNC_DEL_VAL, 8'd0, 32'h7fff_ffff);
    send(FUNC_DEL_VAL, 8'd0, 32'd5);
    // Delete at the rear, at the head, then past the end.
    send(FUNC_DELETE, 8'd4, 32'd0);
    send(FUNC_DELETE, 8'd1, 32'd0);
    send(FUNC_DELETE, 8'd3, 32'd0);
    send(FUNC_SPARE_6, 8'hff, 32'hffff_ffff);
    send(FUNC_SPARE_7, 8'hff, 32'hffff_ffff);
    send(FUNC_CLEAR, 8'd0, 32'd0);
    drain();

    // Random phases; open with a fill so the full cases come up early.
    issued = 0;
    mode   = MODE_FILL;
    while (issued < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      if (phase_len > RANDOM_ITEMS - issued) phase_len = RANDOM_ITEMS - issued;
      no_idle   = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) drain();
      repeat (phase_len) begin
        pick_request(mode, f, p, v);
        send(f, p, v);
        issued++;
      end
      mode = $urandom_range(MODE_FILL, MODE_CHURN);
    end
    start <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.faults == 0 && tracker.awaited.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/isl_pkg.sv
sv/isl_dpath.sv
sv/isl_ctrl.sv
sv/indexed_sequential_list_top.sv
sv/isl_checker.sv
sim/testbench.sv
